>>> hdl/altr_pkg.sv
// Package for the arc-length table block: request and result structs,
// controller command and status types, and fixed field widths. No dependencies.
package altr_pkg;

    // Table geometry and number formats.
    localparam int SEGMENTS    = 200;
    localparam int T_FRAC_BITS = 16;
    localparam int DIST_WIDTH  = 31;

    localparam int ModeW  = 2;
    localparam int IndexW = 8;
    localparam int FieldDistW = DIST_WIDTH;
    localparam int FieldTW = T_FRAC_BITS + 1;
    localparam int SignedDistW = 32;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_T2D  = 2'd1;
    localparam logic [1:0] MODE_D2T  = 2'd2;
    localparam logic [1:0] MODE_ADV  = 2'd3;

    typedef struct packed {
        logic [ModeW-1:0]       mode;
        logic [IndexW-1:0]      entry_index;
        logic [FieldDistW-1:0]  entry_distance;
        logic [FieldTW-1:0]     param_t;
        logic signed [SignedDistW-1:0] distance;
    } request_t;

    typedef struct packed {
        logic                  status;
        logic [FieldTW-1:0]    result_t;
        logic [FieldDistW-1:0] result_distance;
    } result_t;

    // Datapath operation selected by the controller in each cycle.
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_CAPT  = 4'd1,   // capture request, issue first read
        OP_T2DA  = 4'd2,   // latch D[i], read D[i+1]
        OP_T2DB  = 4'd3,   // latch D[i+1], form interpolation
        OP_ADDD  = 4'd4,   // form query distance, read D[SEGMENTS]
        OP_CHKE  = 4'd5,   // compare against end entry
        OP_SRCH  = 4'd6,   // one binary search phase (read or compare)
        OP_BRKA  = 4'd7,   // read D[is]
        OP_BRKB  = 4'd8,   // latch D[is], read D[ie]
        OP_BRKC  = 4'd9,   // latch D[ie], form num and den
        OP_DIVP  = 4'd10,  // form dividend and divisor
        OP_DIVS  = 4'd11,  // one divider step
        OP_MULB  = 4'd12   // second interpolation product stage
    } dp_op_t;

    typedef struct packed {
        logic search_done;
        logic div_done;
        logic end_hit;
        logic low_hit;
    } dp_status_t;

endpackage

>>> hdl/altr_ctrl.sv
// Controller state machine of the arc-length table block.
// Depends on altr_pkg for command and status types.
module altr_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             req_mode,
    input  logic                   loaded,
    input  altr_pkg::dp_status_t   dp_status,
    output altr_pkg::dp_op_t       dp_op,
    output logic                   busy,
    output logic                   done
);
    import altr_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_CAPT = 13'b0000000000010,
        S_T2DA = 13'b0000000000100,
        S_T2DB = 13'b0000000001000,
        S_MULB = 13'b0000000010000,
        S_ADDD = 13'b0000000100000,
        S_CHKE = 13'b0000001000000,
        S_SRCH = 13'b0000010000000,
        S_BRKA = 13'b0000100000000,
        S_BRKB = 13'b0001000000000,
        S_BRKC = 13'b0010000000000,
        S_DIVP = 13'b0100000000000,
        S_DIVS = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   done_next;
    logic [1:0] mode_reg, mode_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
            mode_reg  <= MODE_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            done      <= done_next;
            mode_reg  <= mode_next;
        end
    end

    // Next state and datapath command.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        mode_next  = mode_reg;
        dp_op      = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    dp_op      = OP_CAPT;
                    mode_next  = req_mode;
                    if (req_mode == MODE_LOAD || !loaded)
                        done_next = 1'b1;
                    else if (req_mode == MODE_D2T)
                        state_next = S_ADDD;
                    else
                        state_next = S_T2DA;
                end
            end
            S_CAPT:
                state_next = S_IDLE;
            S_T2DA:
            begin
                dp_op      = OP_T2DA;
                state_next = S_T2DB;
            end
            S_T2DB:
            begin
                dp_op      = OP_T2DB;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                dp_op = OP_MULB;
                if (mode_reg == MODE_T2D)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_ADDD;
            end
            S_ADDD:
            begin
                dp_op      = OP_ADDD;
                state_next = S_CHKE;
            end
            S_CHKE:
            begin
                dp_op = OP_CHKE;
                if (dp_status.low_hit || dp_status.end_hit)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_SRCH;
            end
            S_SRCH:
            begin
                dp_op = OP_SRCH;
                if (dp_status.search_done)
                    state_next = S_BRKA;
            end
            S_BRKA:
            begin
                dp_op      = OP_BRKA;
                state_next = S_BRKB;
            end
            S_BRKB:
            begin
                dp_op      = OP_BRKB;
                state_next = S_BRKC;
            end
            S_BRKC:
            begin
                dp_op      = OP_BRKC;
                state_next = S_DIVP;
            end
            S_DIVP:
            begin
                dp_op      = OP_DIVP;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                dp_op = OP_DIVS;
                if (dp_status.div_done)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE) || done;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("controller state not one-hot");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("done raised outside idle");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");
`endif

endmodule

>>> hdl/altr_dp.sv
// Datapath of the arc-length table block: table memory, interpolation,
// binary search and restoring divider. Depends on altr_pkg.
module altr_dp
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  altr_pkg::dp_op_t       dp_op,
    input  altr_pkg::request_t     request,
    output logic                   loaded,
    output altr_pkg::dp_status_t   dp_status,
    output altr_pkg::result_t      result
);
    import altr_pkg::*;

    localparam int IW   = $clog2(SEGMENTS + 1);
    localparam int TW   = T_FRAC_BITS + 1;
    localparam int SW   = $clog2(SEGMENTS + 1);
    localparam int PW   = TW + SW;
    localparam int QW   = DIST_WIDTH + 2;     // signed query width
    localparam int NW   = DIST_WIDTH + SW + 1; // dividend / divisor width
    localparam int CW   = $clog2(T_FRAC_BITS + 1);
    localparam logic [IW-1:0] LAST = IW'(SEGMENTS);
    localparam logic [TW-1:0] ONE  = TW'(1) << T_FRAC_BITS;
    localparam int HW   = (DIST_WIDTH > 24) ? DIST_WIDTH - 24 : 1;

    // Table memory with registered read.
    logic [DIST_WIDTH-1:0] mem [0:SEGMENTS];
    logic [DIST_WIDTH-1:0] rdata_reg;
    logic [IW-1:0]         raddr;
    logic                  valid_reg;

    logic [1:0]            mode_reg;
    logic [TW-1:0]         t_reg;
    logic signed [QW-1:0]  adv_reg;
    logic [DIST_WIDTH-1:0] d0_reg, dt_reg;
    logic [IW-1:0]         i_reg, is_reg, ie_reg;
    logic [T_FRAC_BITS-1:0] f_reg;
    logic                  zero_t_reg, full_t_reg, neg_reg;
    logic [DIST_WIDTH+T_FRAC_BITS-1:0] plo_reg, phi_reg;
    logic signed [QW-1:0]  q_reg;
    logic [DIST_WIDTH:0]   num_reg, den_reg;
    logic [NW+1:0]         rem_reg;
    logic [NW-1:0]         dvs_reg;
    logic [T_FRAC_BITS-1:0] quo_reg;
    logic [CW-1:0]         cnt_reg;
    result_t               result_reg;

    // Search bounds follow the registered memory read of the midpoint in the next cycle,
    // so each step alternates: issue read, then compare.
    logic                  srch_phase_reg;
    logic [IW-1:0]         im_reg;

    // Clamped parameter and its segment split.
    logic [TW-1:0]  t_clamp;
    logic [PW-1:0]  p_full;
    logic [IW-1:0]  im;
    logic signed [QW-1:0] q_sum;
    logic [DIST_WIDTH-1:0] interp;
    logic [NW+1:0]  rem_sh;
    logic signed [QW:0] nd;

    assign t_clamp = (request.param_t > FieldTW'(ONE)) ? ONE : TW'(request.param_t);
    assign p_full  = PW'(t_reg) * PW'(SEGMENTS);
    assign im      = IW'((SW+1)'(is_reg) + (SW+1)'(ie_reg) >> 1);
    assign interp  = neg_reg
        ? d0_reg - DIST_WIDTH'((phi_reg << 24 >> T_FRAC_BITS) + (plo_reg >> T_FRAC_BITS))
        : d0_reg + DIST_WIDTH'((phi_reg << 24 >> T_FRAC_BITS) + (plo_reg >> T_FRAC_BITS));
    assign q_sum   = signed'(QW'({1'b0, dt_reg})) + adv_reg;
    assign rem_sh  = rem_reg << 1;
    assign nd      = signed'((QW+1)'(q_reg)) - signed'((QW+1)'({1'b0, d0_reg}));

    // Read address chosen by operation.
    always_comb
    begin
        raddr = LAST;
        unique case (dp_op)
            OP_CAPT: raddr = (t_clamp >= ONE) ? LAST
                : IW'((PW'(t_clamp) * PW'(SEGMENTS)) >> T_FRAC_BITS);
            OP_T2DA: raddr = (i_reg >= LAST) ? LAST : i_reg + IW'(1);
            OP_SRCH: raddr = im;
            OP_BRKA: raddr = is_reg;
            OP_BRKB: raddr = ie_reg;
            default: raddr = LAST;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dp_op == OP_CAPT && request.mode == MODE_LOAD &&
            request.entry_index <= IndexW'(SEGMENTS))
            mem[IW'(request.entry_index)] <= request.entry_distance[DIST_WIDTH-1:0];
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (dp_op == OP_CAPT && request.mode == MODE_LOAD &&
                 request.entry_index == IndexW'(SEGMENTS))
            valid_reg <= 1'b1;
    end
    assign loaded = valid_reg;

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (dp_op)
            OP_CAPT:
            begin
                mode_reg   <= request.mode;
                t_reg      <= t_clamp;
                adv_reg    <= QW'(request.distance);
                i_reg      <= (t_clamp >= ONE) ? LAST
                    : IW'((PW'(t_clamp) * PW'(SEGMENTS)) >> T_FRAC_BITS);
                zero_t_reg <= (t_clamp == '0);
                full_t_reg <= (t_clamp >= ONE);
                dt_reg     <= '0;
                result_reg <= {(request.mode != MODE_LOAD) && !valid_reg,
                               FieldTW'(0), FieldDistW'(0)};
            end
            OP_T2DA:
            begin
                d0_reg <= rdata_reg;
                f_reg  <= T_FRAC_BITS'(p_full);
            end
            OP_T2DB:
            begin
                neg_reg  <= rdata_reg < d0_reg;
                // products of low 24 bits and high bits by fraction
                plo_reg  <= (DIST_WIDTH+T_FRAC_BITS)'(
                    (DIST_WIDTH+T_FRAC_BITS)'(((rdata_reg >= d0_reg) ? rdata_reg - d0_reg
                        : d0_reg - rdata_reg) & DIST_WIDTH'(24'hFFFFFF))
                    * (DIST_WIDTH+T_FRAC_BITS)'(f_reg));
                phi_reg  <= (DIST_WIDTH+T_FRAC_BITS)'(
                    (DIST_WIDTH+T_FRAC_BITS)'(HW'(((rdata_reg >= d0_reg) ? rdata_reg - d0_reg
                        : d0_reg - rdata_reg) >> 24))
                    * (DIST_WIDTH+T_FRAC_BITS)'(f_reg));
            end
            OP_MULB:
            begin
                if (zero_t_reg)
                    dt_reg <= '0;
                else if (full_t_reg || i_reg >= LAST)
                    dt_reg <= d0_reg;
                else
                    dt_reg <= interp;
                if (mode_reg == MODE_T2D)
                    result_reg.result_distance <= FieldDistW'(zero_t_reg ? '0
                        : (full_t_reg || i_reg >= LAST) ? d0_reg : interp);
            end
            OP_ADDD:
            begin
                q_reg  <= (mode_reg == MODE_D2T) ? adv_reg : q_sum;
                is_reg <= '0;
                ie_reg <= LAST;
            end
            OP_CHKE:
            begin
                if (q_reg <= 0)
                    result_reg.result_t <= '0;
                else if (q_reg >= signed'(QW'({1'b0, rdata_reg})))
                    result_reg.result_t <= FieldTW'(ONE);
            end
            OP_SRCH:
            begin
                // First phase issues the midpoint read, second phase compares.
                if (!srch_phase_reg)
                    im_reg <= im;
                else if (q_reg <= signed'(QW'({1'b0, rdata_reg})))
                    ie_reg <= im_reg;
                else
                    is_reg <= im_reg;
            end
            OP_BRKB:
                d0_reg <= rdata_reg;
            OP_BRKC:
            begin
                if (rdata_reg <= d0_reg)
                begin
                    den_reg <= (DIST_WIDTH+1)'(1);
                    num_reg <= '0;
                end
                else
                begin
                    den_reg <= (DIST_WIDTH+1)'(rdata_reg - d0_reg);
                    num_reg <= (nd < 0) ? '0
                        : (nd > signed'((QW+1)'(rdata_reg - d0_reg)))
                            ? (DIST_WIDTH+1)'(rdata_reg - d0_reg)
                            : (DIST_WIDTH+1)'(nd);
                end
            end
            OP_DIVP:
            begin
                rem_reg <= (NW+2)'(NW'(is_reg) * NW'(den_reg) + NW'(num_reg));
                dvs_reg <= NW'(SEGMENTS) * NW'(den_reg);
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            OP_DIVS:
            begin
                if (rem_reg >= (NW+2)'(dvs_reg))
                begin
                    result_reg.result_t <= FieldTW'(ONE);
                    cnt_reg <= CW'(T_FRAC_BITS);
                end
                else if (rem_sh >= (NW+2)'(dvs_reg))
                begin
                    rem_reg <= rem_sh - (NW+2)'(dvs_reg);
                    quo_reg <= {quo_reg[T_FRAC_BITS-2:0], 1'b1};
                    cnt_reg <= cnt_reg + CW'(1);
                    result_reg.result_t <= FieldTW'({quo_reg[T_FRAC_BITS-2:0], 1'b1});
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[T_FRAC_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg + CW'(1);
                    result_reg.result_t <= FieldTW'({quo_reg[T_FRAC_BITS-2:0], 1'b0});
                end
            end
            default:
            begin
            end
        endcase
    end

    // Search phase toggles on every search cycle and restarts outside the search.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            srch_phase_reg <= 1'b0;
        else if (dp_op == OP_SRCH)
            srch_phase_reg <= !srch_phase_reg;
        else
            srch_phase_reg <= 1'b0;
    end

    assign dp_status.search_done = (ie_reg - is_reg <= IW'(1)) && !srch_phase_reg;
    assign dp_status.div_done    = (rem_reg >= (NW+2)'(dvs_reg)) ||
                                   (cnt_reg == CW'(T_FRAC_BITS - 1));
    assign dp_status.end_hit     = q_reg >= signed'(QW'({1'b0, rdata_reg}));
    assign dp_status.low_hit     = q_reg <= 0;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        dp_op == OP_SRCH |-> is_reg < ie_reg)
        else $error("search bounds crossed");
    a_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        $past(valid_reg) |-> valid_reg)
        else $error("table valid flag cleared");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        dp_op == OP_DIVS |-> cnt_reg < CW'(T_FRAC_BITS))
        else $error("divider ran past its step count");
`endif

endmodule

>>> hdl/arc_length_table_reparameterizer_top.sv
// Arc-length table reparameteriser. Load and unloaded-table requests finish straight from
// idle; mode 1 runs the interpolation states; modes 2 and 3 end at the end-entry check when
// the distance clamps, otherwise they run the binary search, whose steps alternate read and
// compare, then the one-bit-a-cycle divider, and mode 3 runs the interpolation first.
// One request at a time, the next taken the cycle after done; the receiver cannot stall.
// Reset clears the controller, the table valid flag and the search phase flag only.
module arc_length_table_reparameterizer_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  altr_pkg::request_t  request,
    output logic                busy,
    output logic                done,
    output altr_pkg::result_t   result
);
    import altr_pkg::*;

    dp_op_t     dp_op;
    dp_status_t dp_status;
    logic       loaded;

    // Controller.
    altr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start && !busy),
        .req_mode  (request.mode),
        .loaded    (loaded),
        .dp_status (dp_status),
        .dp_op     (dp_op),
        .busy      (busy),
        .done      (done)
    );

    // Datapath.
    altr_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_op     (dp_op),
        .request   (request),
        .loaded    (loaded),
        .dp_status (dp_status),
        .result    (result)
    );

endmodule

>>> sim/arc_length_checker.sv
// Checker for the arc-length table block: watches requests and results,
// predicts each result and compares it. Depends on altr_pkg.
`timescale 1ns / 100ps

module arc_length_checker
    import altr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  request_t  request,
    input  logic      done,
    input  result_t   result,
    output int        fail_count,
    output int        pending_results
);

    localparam int NSEG = 200;
    localparam longint T_ONE = 64'd65536;

    logic [30:0] dist_copy [0:NSEG];
    logic        copy_valid;
    result_t     expected_results [$];

    assign pending_results = expected_results.size();

    // Interpolated distance at parameter t.
    function automatic longint distance_at(longint t);
        longint p, i, f, d0, d1;
        if (t == 0)
        begin
            return 0;
        end
        if (t >= T_ONE)
        begin
            return dist_copy[NSEG];
        end
        p = t * NSEG;
        i = p >> 16;
        f = p & (T_ONE - 1);
        d0 = dist_copy[i];
        d1 = dist_copy[i + 1];
        if (d1 >= d0)
        begin
            return (d0 + (((d1 - d0) * f) >> 16)) & 64'h7FFF_FFFF;
        end
        return (d0 - (((d0 - d1) * f) >> 16)) & 64'h7FFF_FFFF;
    endfunction

    // Parameter at distance d, by search and exact division.
    function automatic longint param_at(longint d);
        longint lo_i, hi_i, mid, lo, hi, num, den, n, q;
        lo_i = 0;
        hi_i = NSEG;
        if (d <= 0)
        begin
            return 0;
        end
        if (d >= longint'(dist_copy[NSEG]))
        begin
            return T_ONE;
        end
        while (hi_i - lo_i > 1)
        begin
            mid = (lo_i + hi_i) >> 1;
            if (d <= longint'(dist_copy[mid]))
                hi_i = mid;
            else
                lo_i = mid;
        end
        lo = dist_copy[lo_i];
        hi = dist_copy[hi_i];
        den = hi - lo;
        num = d - lo;
        if (den <= 0)
        begin
            den = 1;
            num = 0;
        end
        if (num < 0)
            num = 0;
        if (num > den)
            num = den;
        n = lo_i * den + num;
        if (n >= NSEG * den)
        begin
            return T_ONE;
        end
        q = (n * T_ONE) / (NSEG * den);
        return q;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Prediction on each accepted request.
    always @(posedge clk or negedge rst_n)
    begin
        result_t r;
        longint t, d;
        if (!rst_n)
        begin
            copy_valid <= 1'b0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (start && !busy)
            begin
                r = '0;
                t = request.param_t;
                if (t > T_ONE)
                    t = T_ONE;
                d = longint'(request.distance);
                if (request.mode == MODE_LOAD)
                begin
                    if (request.entry_index <= NSEG)
                    begin
                        dist_copy[request.entry_index] = request.entry_distance;
                        if (request.entry_index == NSEG)
                            copy_valid <= 1'b1;
                    end
                end
                else if (!copy_valid)
                    r.status = 1'b1;
                else if (request.mode == MODE_T2D)
                    r.result_distance = distance_at(t);
                else if (request.mode == MODE_D2T)
                    r.result_t = param_at(d);
                else
                    r.result_t = param_at(distance_at(t) + d);
                expected_results.push_back(r);
            end
            // Results are compared against the oldest prediction.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no request outstanding", $realtime);
                    fail_count++;
                end
                else
                begin
                    r = expected_results.pop_front();
                    if (result.status !== r.status)
                        report_mismatch("status", result.status, r.status);
                    if (result.result_t !== r.result_t)
                        report_mismatch("result_t", result.result_t, r.result_t);
                    if (result.result_distance !== r.result_distance)
                        report_mismatch("result_distance", result.result_distance,
                                        r.result_distance);
                end
            end
        end
    end

endmodule

>>> sim/arc_length_table_reparameterizer_top_test.sv
// Top of the arc-length table testbench: clock, reset, request stimulus and
// verdict. Depends on altr_pkg, the block and arc_length_checker.
`timescale 1ns / 100ps

module arc_length_table_reparameterizer_top_test;
    import altr_pkg::*;

    localparam int NSEG = 200;
    localparam int STALL_LIMIT = 2000;

    logic     clk;
    logic     rst_n;
    logic     start;
    request_t request;
    logic     busy;
    logic     done;
    result_t  result;
    int       fail_count;
    int       pending_results;
    int       idle_cycles;
    logic [30:0] table_image [0:NSEG];

    arc_length_table_reparameterizer_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .request(request),
        .busy(busy), .done(done), .result(result)
    );

    arc_length_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .fail_count(fail_count),
        .pending_results(pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: cycles without an accepted request or result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Random filler for the request fields.
    function automatic request_t random_request();
        return request_t'($bits(request_t)'({$urandom, $urandom, $urandom}));
    endfunction

    // Issues one request, waits for it to be taken, then, if gaps is set, may idle a random gap.
    task automatic send_request(input request_t req, input bit gaps);
        int gap;
        start <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = gaps ? $urandom_range(0, 12) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            request <= random_request();
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_entry(input int idx, input logic [30:0] value, input bit gaps);
        request_t req;
        req = random_request();
        req.mode = MODE_LOAD;
        req.entry_index = IndexW'(idx);
        req.entry_distance = value;
        if (idx <= NSEG)
            table_image[idx] = value;
        send_request(req, gaps);
    endtask

    task automatic query(input logic [1:0] mode, input logic [16:0] t,
                         input logic signed [31:0] d, input bit gaps);
        request_t req;
        req = random_request();
        req.mode = mode;
        req.param_t = t;
        req.distance = d;
        send_request(req, gaps);
    endtask

    // Fills the whole table ascending; flat stretches and steep steps at random.
    task automatic load_ascending(input logic [30:0] max_step, input bit gaps);
        logic [31:0] acc;
        acc = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 1000);
        for (int i = 0; i <= NSEG; i++)
        begin
            load_entry(i, acc[30:0], gaps);
            if ($urandom_range(0, 7) != 0)
                acc = acc + ({$urandom} % (max_step + 1));
            if (acc > 32'h7FFF_FFFF)
                acc = 32'h7FFF_FFFF;
        end
    endtask

    function automatic logic signed [31:0] pick_distance();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom;
        if (sel == 1)
            return sel[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        return $urandom_range(0, table_image[NSEG] + 20) - 10;
    endfunction

    function automatic logic [16:0] pick_param();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 17'($urandom);
        if (sel == 1)
            return 17'd65536;
        return 17'($urandom_range(0, 65536));
    endfunction

    initial
    begin
        logic [1:0] m;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: queries before load, out-of-range index, extremes.
        query(MODE_T2D, 17'd100, 32'sd5, 1'b0);
        query(MODE_D2T, 17'd0, -32'sd5, 1'b0);
        query(MODE_ADV, 17'h1FFFF, 32'sh7FFF_FFFF, 1'b0);
        load_entry(255, 31'h7FFF_FFFF, 1'b0);
        load_entry(201, 31'h1234, 1'b0);
        load_ascending(31'd200000, 1'b0);
        query(MODE_T2D, 17'd0, 32'sd0, 1'b0);
        query(MODE_T2D, 17'd65536, 32'sd0, 1'b0);
        query(MODE_T2D, 17'h1FFFF, 32'sd0, 1'b0);
        query(MODE_D2T, 17'd0, 32'sd0, 1'b0);
        query(MODE_D2T, 17'd0, 32'sh8000_0000, 1'b0);
        query(MODE_D2T, 17'd0, 32'sh7FFF_FFFF, 1'b0);
        query(MODE_D2T, 17'd0, 32'(table_image[NSEG]), 1'b0);
        query(MODE_D2T, 17'd0, 32'(table_image[100]), 1'b0);
        query(MODE_ADV, 17'd0, -32'sd1, 1'b0);
        query(MODE_ADV, 17'd32768, 32'sh7FFF_FFFF, 1'b0);
        query(MODE_ADV, 17'd32768, 32'sh8000_0000, 1'b0);
        // A later write keeps the table valid; a descending pair tests the reverse path.
        load_entry(50, 31'h7FFF_FFFF, 1'b0);
        query(MODE_T2D, 17'd16400, 32'sd0, 1'b0);
        query(MODE_D2T, 17'd0, table_image[49] + 1, 1'b0);
        load_entry(50, table_image[49], 1'b0);

        // Random phases: reload the table with new shapes, then query.
        for (int phase = 0; phase < 4; phase++)
        begin
            load_ascending(phase == 3 ? 31'd10700000 : ($urandom_range(0, 1) ? 31'd300 : 31'd70000),
                           1'b1);
            for (int n = 0; n < 100; n++)
            begin
                m = 2'($urandom_range(1, 3));
                if ($urandom_range(0, 40) == 0)
                    load_entry($urandom_range(202, 255), 31'($urandom), 1'b1);
                else
                    query(m, pick_param(), pick_distance(), $urandom_range(0, 2) != 0);
            end
        end
        start <= 1'b0;

        while (pending_results != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
